// ----- rtl/core/lcdseq_pkg.sv -----
// shared types, codes and helpers for the character lcd interface sequencer
package lcdseq_pkg;

  // geometry and queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int ROWS        = 4;
  localparam int COLUMNS     = 20;
  localparam int MAX_RESULTS = 4;

  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int GAP_W     = 10;
  localparam int WAIT_W    = 20;
  localparam int US_PER_MS = 1000;

  // request codes
  localparam logic [2:0] REQ_INIT        = 3'd0;
  localparam logic [2:0] REQ_COMMAND     = 3'd1;
  localparam logic [2:0] REQ_DATA        = 3'd2;
  localparam logic [2:0] REQ_GOTO        = 3'd3;
  localparam logic [2:0] REQ_CHAR        = 3'd4;
  localparam logic [2:0] REQ_DISPLAY     = 3'd5;
  localparam logic [2:0] REQ_BUSY_ANSWER = 3'd6;

  // result action codes
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_BUSYRD = 2'd1;
  localparam logic [1:0] ACT_REJECT = 2'd2;

  // register index of the configuration port
  localparam logic REG_CHAR_GAP = 1'b0;

  // display instruction bytes
  localparam logic [7:0] FUNC_SET    = 8'h38;
  localparam logic [7:0] DISPLAY_ON  = 8'h0E;
  localparam logic [7:0] CLEAR_DISP  = 8'h01;
  localparam logic [7:0] ENTRY_MODE  = 8'h06;
  localparam logic [7:0] SET_ADDR    = 8'h80;
  localparam logic [7:0] DISPLAY_CTL = 8'h0C;

  // power-up delays of the three raw function-set strobes
  localparam logic [WAIT_W-1:0] WAIT_POWER_UP = 20'd45000;
  localparam logic [WAIT_W-1:0] WAIT_SECOND   = 20'd5000;
  localparam logic [WAIT_W-1:0] WAIT_THIRD    = 20'd150;

  typedef enum logic {PH_IDLE, PH_WAIT} phase_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] row;
    logic [7:0] column;
    logic       cursor_on;
    logic       blink_on;
    logic       busy_flag;
  } item_t;

  typedef struct packed {
    logic [1:0]        action;
    logic              reg_select;
    logic [7:0]        bus_byte;
    logic [WAIT_W-1:0] wait_before_us;
    logic [WAIT_W-1:0] wait_after_us;
    logic              last;
  } result_t;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] pending_count;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             gap_flag;
  } ctrl_t;

  // queue entry: register select in bit 8, byte below
  typedef logic [8:0] entry_t;
  typedef entry_t [QUEUE_DEPTH-1:0] queue_t;
  typedef result_t [MAX_RESULTS-1:0] bundle_t;

  function automatic logic [7:0] row_base(input logic [ROW_W-1:0] r);
    logic [1:0] rr;
    rr = 2'(r);
    case (rr)
      2'd0:    row_base = 8'd0;
      2'd1:    row_base = 8'd64;
      2'd2:    row_base = 8'd20;
      default: row_base = 8'd84;
    endcase
  endfunction

  function automatic logic [7:0] address_of(input logic [ROW_W-1:0] r,
                                            input logic [COL_W-1:0] c);
    address_of = SET_ADDR | (row_base(r) + 8'(c));
  endfunction

  function automatic result_t make_result(input logic [1:0] action,
                                          input logic rs,
                                          input logic [7:0] byte_val,
                                          input logic [WAIT_W-1:0] wb,
                                          input logic [WAIT_W-1:0] wa,
                                          input logic last);
    result_t r;
    r.action         = action;
    r.reg_select     = rs;
    r.bus_byte       = byte_val;
    r.wait_before_us = wb;
    r.wait_after_us  = wa;
    r.last           = last;
    make_result = r;
  endfunction

endpackage

// ----- rtl/core/lcdseq_step.sv -----
// next-state and result logic for one registered request
module lcdseq_step import lcdseq_pkg::*; (
  input  item_t                   item,
  input  ctrl_t                   ctrl,
  input  queue_t                  queue,
  input  logic [WAIT_W-1:0]       gap_us,
  output ctrl_t                   ctrl_next,
  output queue_t                  queue_next,
  output bundle_t                 results,
  output logic [RES_CNT_W-1:0]    result_count
);

  logic [CNT_W-1:0]  remain;
  logic              goto_ok;
  logic [ROW_W-1:0]  goto_row;
  logic [COL_W-1:0]  goto_col;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic              col_wrap;
  logic [ROW_W-1:0]  char_row;
  logic [COL_W-1:0]  char_col;
  logic [WAIT_W-1:0] wa;
  result_t           reject_res;
  result_t           busyrd_res;

  assign remain = ctrl.pending_count - CNT_W'(1);

  // goto target, out of range falls back to home
  assign goto_ok  = (item.row < 8'(ROWS)) && (item.column < 8'(COLUMNS));
  assign goto_row = goto_ok ? item.row[ROW_W-1:0] : '0;
  assign goto_col = goto_ok ? item.column[COL_W-1:0] : '0;

  // wrapping character: column first, then row, back to home past the end
  assign col_inc  = {1'b0, ctrl.cursor_col} + (COL_W+1)'(1);
  assign row_inc  = {1'b0, ctrl.cursor_row} + (ROW_W+1)'(1);
  assign col_wrap = (col_inc >= (COL_W+1)'(COLUMNS));
  assign char_col = col_wrap ? '0 : col_inc[COL_W-1:0];
  assign char_row = !col_wrap ? ctrl.cursor_row :
                    (row_inc >= (ROW_W+1)'(ROWS)) ? '0 : row_inc[ROW_W-1:0];

  assign wa = (remain == '0 && ctrl.gap_flag) ? gap_us : '0;

  assign reject_res = make_result(ACT_REJECT, 1'b0, 8'd0, '0, '0, 1'b1);
  assign busyrd_res = make_result(ACT_BUSYRD, 1'b0, 8'd0, '0, '0, 1'b1);

  always_comb begin
    ctrl_next    = ctrl;
    queue_next   = queue;
    results      = '0;
    results[0]   = reject_res;
    result_count = RES_CNT_W'(1);

    if (ctrl.phase == PH_WAIT) begin
      if (item.req_type != REQ_BUSY_ANSWER || ctrl.pending_count == '0) begin
        results[0] = reject_res;
      end else if (item.busy_flag) begin
        results[0] = busyrd_res;
      end else begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          queue_next[i] = queue[i+1];
        end
        ctrl_next.pending_count = remain;
        if (remain != '0) begin
          results[0]   = make_result(ACT_WRITE, queue[0][8], queue[0][7:0], '0, wa, 1'b0);
          results[1]   = busyrd_res;
          result_count = RES_CNT_W'(2);
        end else begin
          results[0]         = make_result(ACT_WRITE, queue[0][8], queue[0][7:0], '0, wa, 1'b1);
          ctrl_next.phase    = PH_IDLE;
          ctrl_next.gap_flag = 1'b0;
        end
      end
    end else begin
      ctrl_next.pending_count = '0;
      ctrl_next.gap_flag      = 1'b0;
      results[0]              = busyrd_res;
      ctrl_next.phase         = PH_WAIT;
      case (item.req_type)
        REQ_INIT: begin
          results[0]   = make_result(ACT_WRITE, 1'b0, FUNC_SET, WAIT_POWER_UP, '0, 1'b0);
          results[1]   = make_result(ACT_WRITE, 1'b0, FUNC_SET, WAIT_SECOND, '0, 1'b0);
          results[2]   = make_result(ACT_WRITE, 1'b0, FUNC_SET, WAIT_THIRD, '0, 1'b0);
          results[3]   = busyrd_res;
          result_count = RES_CNT_W'(4);
          queue_next[0] = {1'b0, FUNC_SET};
          queue_next[1] = {1'b0, DISPLAY_ON};
          queue_next[2] = {1'b0, CLEAR_DISP};
          queue_next[3] = {1'b0, ENTRY_MODE};
          ctrl_next.pending_count = CNT_W'(4);
        end
        REQ_COMMAND: begin
          queue_next[0]           = {1'b0, item.data_byte};
          ctrl_next.pending_count = CNT_W'(1);
        end
        REQ_DATA: begin
          queue_next[0]           = {1'b1, item.data_byte};
          ctrl_next.pending_count = CNT_W'(1);
        end
        REQ_GOTO: begin
          ctrl_next.cursor_row    = goto_row;
          ctrl_next.cursor_col    = goto_col;
          queue_next[0]           = {1'b0, address_of(goto_row, goto_col)};
          ctrl_next.pending_count = CNT_W'(1);
        end
        REQ_CHAR: begin
          ctrl_next.cursor_row    = char_row;
          ctrl_next.cursor_col    = char_col;
          queue_next[0]           = {1'b1, item.data_byte};
          queue_next[1]           = {1'b0, address_of(char_row, char_col)};
          ctrl_next.pending_count = CNT_W'(2);
          ctrl_next.gap_flag      = 1'b1;
        end
        REQ_DISPLAY: begin
          queue_next[0] = {1'b0, DISPLAY_CTL | {6'd0, item.cursor_on, item.blink_on}};
          ctrl_next.pending_count = CNT_W'(1);
        end
        default: begin
          // busy answer while idle and the unused code
          results[0]      = reject_res;
          ctrl_next.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/char_lcd_parallel_interface_sequencer_top.sv -----
// top level of the character lcd interface sequencer
// Turns host requests into strobes for an HD44780-style display on an 8-bit
// bus. Each request is taken into an input register and evaluated
// combinationally; its results (one to four) land in a result buffer that
// drains one transfer per cycle on the master side while m_tready is high;
// a new request is taken when the buffer is empty or on its final transfer.
// Init gives three raw function-set strobes with their
// power-up delays and a busy-read; every other queued byte waits for a busy
// answer request that reports clear. While a busy answer is pending, any
// other request is rejected and the queue is kept. The character gap
// register is scaled to microseconds when written.
module char_lcd_parallel_interface_sequencer_top import lcdseq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // data_byte, row, column, cursor_on, blink_on, busy_flag
  input  logic [2:0]  s_tuser,   // req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // bus_byte, wait_before_us, wait_after_us
  output logic [2:0]  m_tuser,   // action, reg_select
  output logic        m_tlast,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [GAP_W-1:0]  char_gap_ms;
  logic [WAIT_W-1:0] gap_us;
  logic              cfg_write;

  // input register
  logic  in_valid;
  item_t in_item;
  logic  s_transfer;
  logic  process;

  // sequencer state
  ctrl_t  ctrl;
  ctrl_t  ctrl_next;
  queue_t queue;
  queue_t queue_next;

  // result buffer
  bundle_t               results;
  logic [RES_CNT_W-1:0]  result_count;
  bundle_t               bundle;
  logic [RES_CNT_W-1:0]  remaining;
  logic                  buf_free;
  logic                  m_transfer;

  // apb: register index lives in paddr[2], writes complete in the access cycle
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_CHAR_GAP) ? 32'(char_gap_ms) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_gap_ms <= '0;
      gap_us      <= '0;
    end else if (cfg_write && paddr[2] == REG_CHAR_GAP) begin
      char_gap_ms <= pwdata[GAP_W-1:0];
      gap_us      <= WAIT_W'(pwdata[GAP_W-1:0]) * WAIT_W'(US_PER_MS);
    end
  end

  // the buffer can take a new bundle when empty or on its final transfer
  assign m_transfer = m_tvalid && m_tready;
  assign buf_free   = (remaining == '0) || (m_tready && remaining == RES_CNT_W'(1));
  assign process    = in_valid && buf_free;
  assign s_tready   = !in_valid || process;
  assign s_transfer = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_transfer) begin
      in_valid <= 1'b1;
    end else if (process) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_transfer) begin
      in_item.req_type  <= s_tuser;
      in_item.data_byte <= s_tdata[7:0];
      in_item.row       <= s_tdata[15:8];
      in_item.column    <= s_tdata[23:16];
      in_item.cursor_on <= s_tdata[24];
      in_item.blink_on  <= s_tdata[25];
      in_item.busy_flag <= s_tdata[26];
    end
  end

  lcdseq_step u_step (
    .item         (in_item),
    .ctrl         (ctrl),
    .queue        (queue),
    .gap_us       (gap_us),
    .ctrl_next    (ctrl_next),
    .queue_next   (queue_next),
    .results      (results),
    .result_count (result_count)
  );

  // sequencer state advances once per processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase         <= PH_IDLE;
      ctrl.pending_count <= '0;
      ctrl.cursor_row    <= '0;
      ctrl.cursor_col    <= '0;
      ctrl.gap_flag      <= 1'b0;
    end else if (process) begin
      ctrl <= ctrl_next;
    end
  end

  // queue entries are only read below the fill count, no reset needed
  always_ff @(posedge clk) begin
    if (process) begin
      queue <= queue_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (process) begin
      remaining <= result_count;
    end else if (m_transfer) begin
      remaining <= remaining - RES_CNT_W'(1);
    end
  end

  // results shift toward slot 0 as they leave
  always_ff @(posedge clk) begin
    if (process) begin
      bundle <= results;
    end else if (m_transfer) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        bundle[i] <= bundle[i+1];
      end
    end
  end

  assign m_tvalid = (remaining != '0);
  assign m_tdata  = {bundle[0].wait_after_us, bundle[0].wait_before_us, bundle[0].bus_byte};
  assign m_tuser  = {bundle[0].reg_select, bundle[0].action};
  assign m_tlast  = bundle[0].last;

endmodule

// ----- rtl/core/lcdseq_checker.sv -----
// port-level assertions for the character lcd interface sequencer
module lcdseq_checker import lcdseq_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  // a reject always closes its request
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == ACT_REJECT |-> m_tlast)
    else $error("reject not marked last");

  // a busy read always closes its request
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == ACT_BUSYRD |-> m_tlast)
    else $error("busy read not marked last");

  // only write strobes carry a byte, delays or register select
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != ACT_WRITE |-> m_tdata == '0 && !m_tuser[2])
    else $error("payload on a non-write result");

endmodule

bind char_lcd_parallel_interface_sequencer_top lcdseq_checker u_checker (.*);
